// File: design/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debounce / auto-repeat
// Widths, register indexes, event kinds, sequencer states and the structs
// that travel between the block's modules.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int TIME_W          = 32;
	localparam int CFG_W           = 16;
	localparam int BTN_W           = 3;
	localparam int KIND_W          = 2;
	localparam int MASK_W          = 5;
	localparam int CFG_IDX_W       = 3;

	localparam int NUM_BUTTONS_DEF = 5;
	localparam int MAX_BURST_DEF   = 16;
	localparam int MAX_RESULTS     = 35;
	localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

	localparam logic [CFG_W-1:0]  DEBOUNCE_RST     = CFG_W'(20);
	localparam logic [CFG_W-1:0]  LONG_PRESS_RST   = CFG_W'(800);
	localparam logic [CFG_W-1:0]  REPEAT_DELAY_RST = CFG_W'(400);
	localparam logic [CFG_W-1:0]  REPEAT_PERIOD_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0]  FAST_AFTER_RST   = CFG_W'(2000);
	localparam logic [MASK_W-1:0] REPEAT_MASK_RST  = MASK_W'(3);

	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE      = 3'd0,
		CFG_LONG_PRESS    = 3'd1,
		CFG_REPEAT_DELAY  = 3'd2,
		CFG_REPEAT_PERIOD = 3'd3,
		CFG_FAST_AFTER    = 3'd4,
		CFG_REPEAT_MASK   = 3'd5
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS   = 2'd0,
		KIND_REPEAT  = 2'd1,
		KIND_HOLD    = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_EDGE_EMIT,
		ST_P_HEAD,
		ST_P_CLASS,
		ST_P_HOLD,
		ST_P_FAST,
		ST_P_LOOP,
		ST_P_ADD,
		ST_DONE
	} state_t;

	// shared adder/comparator: res = a +/- b, ge = res >= thr
	typedef struct packed {
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		logic [CFG_W-1:0]  thr;
		logic              sub;
	} alu_op_t;

	typedef struct packed {
		logic [TIME_W-1:0] res;
		logic              ge;
	} alu_res_t;

	// per-button state write request
	typedef struct packed {
		logic              edge_we;
		logic              down;
		logic              rt_we;
		logic              hold_set;
		logic [TIME_W-1:0] time_val;
		logic [TIME_W-1:0] rt_val;
	} btn_wr_t;

	typedef struct packed {
		logic              held;
		logic              hold_sent;
		logic [TIME_W-1:0] edge_time;
		logic [TIME_W-1:0] press_time;
		logic [TIME_W-1:0] repeat_time;
	} btn_rd_t;

	typedef struct packed {
		logic [BTN_W-1:0]  btn;
		kind_t             kind;
		logic              fast;
		logic [TIME_W-1:0] tstamp;
	} evt_t;

	typedef struct packed {
		logic push;
		logic flush;
		evt_t evt;
	} ostage_ctl_t;

	typedef struct packed {
		logic hold_v;
		logic emit_ok;
		logic out_free;
	} ostage_sts_t;

endpackage

// File: design/bda_if.sv
// ----------------------------------------------------------------------------
// bda_if: valid/ready channels of the button debounce / auto-repeat block
// Input item channel, event channel and configuration write channel.
// ----------------------------------------------------------------------------
interface bda_in_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [bda_pkg::BTN_W-1:0]   button;
	logic                        level_down;
	logic [bda_pkg::TIME_W-1:0]  now_ms;

	modport source (output valid, func, button, level_down, now_ms, input ready);
	modport sink   (input valid, func, button, level_down, now_ms, output ready);
endinterface

interface bda_out_if;
	logic                        valid;
	logic                        ready;
	logic [bda_pkg::BTN_W-1:0]   event_button;
	logic [bda_pkg::KIND_W-1:0]  event_kind;
	logic                        fast_flag;
	logic [bda_pkg::TIME_W-1:0]  event_time;
	logic                        last_of_run;

	modport source (output valid, event_button, event_kind, fast_flag, event_time,
		last_of_run, input ready);
	modport sink   (input valid, event_button, event_kind, fast_flag, event_time,
		last_of_run, output ready);
endinterface

interface bda_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bda_pkg::CFG_IDX_W-1:0] index;
	logic [bda_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/bda_alu.sv
// ----------------------------------------------------------------------------
// bda_alu: shared 32-bit add/subtract with threshold compare
// Every time difference, threshold test and repeat-time step goes through here.
// ----------------------------------------------------------------------------
module bda_alu (
	input  bda_pkg::alu_op_t  op,
	output bda_pkg::alu_res_t res
);

	logic [bda_pkg::TIME_W-1:0] sum;

	// wraps modulo 2^32
	assign sum     = op.sub ? (op.a - op.b) : (op.a + op.b);
	assign res.res = sum;
	assign res.ge  = (sum >= {{(bda_pkg::TIME_W - bda_pkg::CFG_W){1'b0}}, op.thr});

endmodule

// File: design/bda_btn_regs.sv
// ----------------------------------------------------------------------------
// bda_btn_regs: per-button qualifier state
// Edge time, held flag, press time, repeat time and hold-sent flag, one read
// and one write port at the button the sequencer points to.
// ----------------------------------------------------------------------------
module bda_btn_regs #(
	parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF,
	localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BW-1:0]     idx,
	input  bda_pkg::btn_wr_t  wr,
	output bda_pkg::btn_rd_t  rd
);

	logic [bda_pkg::TIME_W-1:0] edge_time_q   [NUM_BUTTONS];
	logic [bda_pkg::TIME_W-1:0] press_time_q  [NUM_BUTTONS];
	logic [bda_pkg::TIME_W-1:0] repeat_time_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]     held_q;
	logic [NUM_BUTTONS-1:0]     hold_sent_q;
	logic                       in_range;

	assign in_range = (int'(idx) < NUM_BUTTONS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				edge_time_q[i]   <= '0;
				press_time_q[i]  <= '0;
				repeat_time_q[i] <= '0;
			end
			held_q      <= '0;
			hold_sent_q <= '0;
		end else if (in_range) begin
			if (wr.edge_we) begin
				edge_time_q[idx] <= wr.time_val;
				held_q[idx]      <= wr.down;
				if (wr.down) begin
					press_time_q[idx]  <= wr.time_val;
					repeat_time_q[idx] <= wr.time_val;
					hold_sent_q[idx]   <= 1'b0;
				end
			end
			if (wr.rt_we) begin
				repeat_time_q[idx] <= wr.rt_val;
			end
			if (wr.hold_set) begin
				hold_sent_q[idx] <= 1'b1;
			end
		end
	end

	// out-of-range index reads as a released button
	always_comb begin
		rd = '0;
		if (in_range) begin
			rd.held        = held_q[idx];
			rd.hold_sent   = hold_sent_q[idx];
			rd.edge_time   = edge_time_q[idx];
			rd.press_time  = press_time_q[idx];
			rd.repeat_time = repeat_time_q[idx];
		end
	end

endmodule

// File: design/bda_out_stage.sv
// ----------------------------------------------------------------------------
// bda_out_stage: event staging and output register
// One event is held back until the next one (or the end of the item) shows
// whether it closes the run; then it moves to the output register.
// ----------------------------------------------------------------------------
module bda_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bda_pkg::ostage_ctl_t  ctl,
	output bda_pkg::ostage_sts_t  sts,
	bda_out_if.source             out_ch
);

	bda_pkg::evt_t hold_q;
	bda_pkg::evt_t out_q;
	logic          hold_v_q;
	logic          out_valid_q;
	logic          out_last_q;
	logic          out_free;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign sts.hold_v   = hold_v_q;
	assign sts.emit_ok  = !hold_v_q || out_free;
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_valid_q <= 1'b1;
				end else if (out_ch.ready) begin
					out_valid_q <= 1'b0;
				end
			end else if (ctl.flush) begin
				hold_v_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			hold_q <= ctl.evt;
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
		end else if (ctl.flush) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_button = out_q.btn;
	assign out_ch.event_kind   = out_q.kind;
	assign out_ch.fast_flag    = out_q.fast;
	assign out_ch.event_time   = out_q.tstamp;
	assign out_ch.last_of_run  = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (!hold_v_q || out_free))
		else $error("event pushed with no room");
	a_flush_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |-> (hold_v_q && out_free && !ctl.push))
		else $error("flush without staged event or room");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |=> (!hold_v_q && out_valid_q && out_last_q))
		else $error("flush did not close the run");

endmodule

// File: design/button_debounce_autorepeat.sv
// Flow: an edge item passes ST_EDGE (debounce test) and ST_EDGE_EMIT, and its press or
// release reaches the output register in ST_DONE. A poll walks every button from ST_P_HEAD;
// a held button is classed and may get a hold, or, past the repeat delay, a burst of repeats
// from ST_P_LOOP and ST_P_ADD; output stalls hold any emit. One shared adder/compare
// unit serves every step. Ready is low until the item's last event is in the output reg.
// Reset: async, active low; buttons released, timers zero, registers at reset values.
// ----------------------------------------------------------------------------
// button_debounce_autorepeat: five-button keypad qualifier
// Per-button debounce of pin edges, long-press hold events and typematic
// auto-repeat with fast flag, walked by a small sequencer.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat #(
	parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF,
	parameter int MAX_BURST   = bda_pkg::MAX_BURST_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bda_cfg_if.sink    cfg_ch,
	bda_in_if.sink     in_ch,
	bda_out_if.source  out_ch
);

	localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;  // button index
	localparam int IW = $clog2(NUM_BUTTONS + 1);                       // walk counter
	localparam int NW = $clog2(MAX_BURST + 1);                         // burst counter
	localparam int CW = bda_pkg::CNT_W;                                // events this item
	localparam int TW = bda_pkg::TIME_W;

	// ---------------- configuration registers ----------------
	logic [bda_pkg::CFG_W-1:0]  debounce_q;
	logic [bda_pkg::CFG_W-1:0]  long_press_q;
	logic [bda_pkg::CFG_W-1:0]  repeat_delay_q;
	logic [bda_pkg::CFG_W-1:0]  repeat_period_q;
	logic [bda_pkg::CFG_W-1:0]  fast_after_q;
	logic [bda_pkg::MASK_W-1:0] repeat_mask_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= bda_pkg::DEBOUNCE_RST;
			long_press_q    <= bda_pkg::LONG_PRESS_RST;
			repeat_delay_q  <= bda_pkg::REPEAT_DELAY_RST;
			repeat_period_q <= bda_pkg::REPEAT_PERIOD_RST;
			fast_after_q    <= bda_pkg::FAST_AFTER_RST;
			repeat_mask_q   <= bda_pkg::REPEAT_MASK_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				bda_pkg::CFG_DEBOUNCE:      debounce_q      <= cfg_ch.data;
				bda_pkg::CFG_LONG_PRESS:    long_press_q    <= cfg_ch.data;
				bda_pkg::CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_ch.data;
				bda_pkg::CFG_REPEAT_PERIOD: repeat_period_q <= cfg_ch.data;
				bda_pkg::CFG_FAST_AFTER:    fast_after_q    <= cfg_ch.data;
				bda_pkg::CFG_REPEAT_MASK:
					repeat_mask_q <= cfg_ch.data[bda_pkg::MASK_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	bda_pkg::state_t st_q, st_d;

	logic                       func_q;
	logic [bda_pkg::BTN_W-1:0]  btn_q;
	logic                       level_q;
	logic [TW-1:0]              now_q;
	logic [TW-1:0]              held_for_q;
	logic                       fast_q;
	logic [IW-1:0]              idx_q;
	logic [NW-1:0]              n_q;
	logic [CW-1:0]              count_q;

	logic                       in_acc;
	logic                       idx_inc;
	logic                       held_for_ld;
	logic                       fast_ld;
	logic                       n_clr;

	bda_pkg::alu_op_t           alu_op;
	bda_pkg::alu_res_t          alu_res;
	bda_pkg::btn_wr_t           regs_wr;
	bda_pkg::btn_rd_t           regs_rd;
	bda_pkg::ostage_ctl_t       os_ctl;
	bda_pkg::ostage_sts_t       os_sts;

	logic [BW-1:0]              regs_idx;
	logic                       btn_in_range;
	logic                       repeating;
	logic                       edge_ok;
	logic                       budget_ok;
	logic                       loop_go;
	logic                       walk_end;

	assign in_ch.ready = (st_q == bda_pkg::ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// edges address the sampled button, polls the walk counter
	assign regs_idx     = (func_q == bda_pkg::FUNC_EDGE) ? BW'(btn_q) : idx_q[BW-1:0];
	assign btn_in_range = (int'(btn_q) < NUM_BUTTONS);
	assign walk_end     = (idx_q == IW'(NUM_BUTTONS));
	assign budget_ok    = (count_q < CW'(bda_pkg::MAX_RESULTS));

	// debounced edge: level change and enough time since the last accepted edge
	assign edge_ok = btn_in_range && alu_res.ge && (level_q != regs_rd.held);

	// another repeat is owed and both burst and item budget allow it
	assign loop_go = alu_res.ge && (n_q < NW'(MAX_BURST)) && budget_ok;

	// mask covers the first buttons only; the rest never repeat
	always_comb begin
		repeating = 1'b0;
		for (int i = 0; i < bda_pkg::MASK_W; i++) begin
			if (i < NUM_BUTTONS) begin
				if (idx_q == IW'(i)) begin
					repeating = repeat_mask_q[i];
				end
			end
		end
	end

	// ---------------- next state ----------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			bda_pkg::ST_IDLE: begin
				if (in_acc) begin
					st_d = (in_ch.func == bda_pkg::FUNC_POLL) ? bda_pkg::ST_P_HEAD
					                                          : bda_pkg::ST_EDGE;
				end
			end
			bda_pkg::ST_EDGE: begin
				st_d = edge_ok ? bda_pkg::ST_EDGE_EMIT : bda_pkg::ST_DONE;
			end
			bda_pkg::ST_EDGE_EMIT: begin
				if (os_sts.emit_ok) begin
					st_d = bda_pkg::ST_DONE;
				end
			end
			bda_pkg::ST_P_HEAD: begin
				if (walk_end) begin
					st_d = bda_pkg::ST_DONE;
				end else if (regs_rd.held) begin
					st_d = bda_pkg::ST_P_CLASS;
				end
			end
			bda_pkg::ST_P_CLASS: begin
				if (repeating) begin
					st_d = alu_res.ge ? bda_pkg::ST_P_FAST : bda_pkg::ST_P_HEAD;
				end else if (!regs_rd.hold_sent && alu_res.ge && budget_ok) begin
					st_d = bda_pkg::ST_P_HOLD;
				end else begin
					st_d = bda_pkg::ST_P_HEAD;
				end
			end
			bda_pkg::ST_P_HOLD: begin
				if (os_sts.emit_ok) begin
					st_d = bda_pkg::ST_P_HEAD;
				end
			end
			bda_pkg::ST_P_FAST: begin
				st_d = bda_pkg::ST_P_LOOP;
			end
			bda_pkg::ST_P_LOOP: begin
				if (!loop_go) begin
					st_d = bda_pkg::ST_P_HEAD;
				end else if (os_sts.emit_ok) begin
					st_d = bda_pkg::ST_P_ADD;
				end
			end
			bda_pkg::ST_P_ADD: begin
				st_d = bda_pkg::ST_P_LOOP;
			end
			bda_pkg::ST_DONE: begin
				if (!os_sts.hold_v || os_sts.out_free) begin
					st_d = bda_pkg::ST_IDLE;
				end
			end
			default: st_d = bda_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		alu_op         = '0;
		alu_op.sub     = 1'b1;
		regs_wr        = '0;
		regs_wr.down   = level_q;
		regs_wr.time_val = now_q;
		regs_wr.rt_val = now_q;
		os_ctl         = '0;
		os_ctl.evt.btn = (func_q == bda_pkg::FUNC_EDGE) ? btn_q
		                                                : bda_pkg::BTN_W'(idx_q);
		os_ctl.evt.kind   = bda_pkg::KIND_PRESS;
		os_ctl.evt.tstamp = now_q;
		idx_inc     = 1'b0;
		held_for_ld = 1'b0;
		fast_ld     = 1'b0;
		n_clr       = 1'b0;

		unique case (st_q)
			bda_pkg::ST_EDGE: begin
				alu_op.a   = now_q;
				alu_op.b   = regs_rd.edge_time;
				alu_op.thr = debounce_q;
			end
			bda_pkg::ST_EDGE_EMIT: begin
				os_ctl.evt.kind = level_q ? bda_pkg::KIND_PRESS : bda_pkg::KIND_RELEASE;
				if (os_sts.emit_ok) begin
					os_ctl.push     = 1'b1;
					regs_wr.edge_we = 1'b1;
				end
			end
			bda_pkg::ST_P_HEAD: begin
				alu_op.a    = now_q;
				alu_op.b    = regs_rd.press_time;
				held_for_ld = 1'b1;
				idx_inc     = !walk_end && !regs_rd.held;
			end
			bda_pkg::ST_P_CLASS: begin
				alu_op.a   = held_for_q;
				alu_op.thr = repeating ? repeat_delay_q : long_press_q;
				idx_inc    = (st_d == bda_pkg::ST_P_HEAD);
			end
			bda_pkg::ST_P_HOLD: begin
				os_ctl.evt.kind = bda_pkg::KIND_HOLD;
				if (os_sts.emit_ok) begin
					os_ctl.push      = 1'b1;
					regs_wr.hold_set = 1'b1;
					idx_inc          = 1'b1;
				end
			end
			bda_pkg::ST_P_FAST: begin
				alu_op.a   = held_for_q;
				alu_op.thr = fast_after_q;
				fast_ld    = 1'b1;
				n_clr      = 1'b1;
			end
			bda_pkg::ST_P_LOOP: begin
				alu_op.a        = now_q;
				alu_op.b        = regs_rd.repeat_time;
				alu_op.thr      = repeat_period_q;
				os_ctl.evt.kind = bda_pkg::KIND_REPEAT;
				os_ctl.evt.fast = fast_q;
				if (loop_go) begin
					os_ctl.push = os_sts.emit_ok;
				end else begin
					// burst cut short with time still owed: drop it
					regs_wr.rt_we = alu_res.ge;
					idx_inc       = 1'b1;
				end
			end
			bda_pkg::ST_P_ADD: begin
				alu_op.a       = regs_rd.repeat_time;
				alu_op.b       = {{(TW - bda_pkg::CFG_W){1'b0}}, repeat_period_q};
				alu_op.sub     = 1'b0;
				regs_wr.rt_we  = 1'b1;
				regs_wr.rt_val = alu_res.res;
			end
			bda_pkg::ST_DONE: begin
				os_ctl.flush = os_sts.hold_v && os_sts.out_free;
			end
			default: ;
		endcase
	end

	// ---------------- sequencer registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= bda_pkg::ST_IDLE;
			idx_q   <= '0;
			n_q     <= '0;
			count_q <= '0;
		end else begin
			st_q <= st_d;
			if (in_acc) begin
				idx_q   <= '0;
				count_q <= '0;
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
				if (os_ctl.push) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (n_clr) begin
				n_q <= '0;
			end else if (os_ctl.push && st_q == bda_pkg::ST_P_LOOP) begin
				n_q <= n_q + NW'(1);
			end
		end
	end

	// item fields and per-button scratch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= in_ch.func;
			btn_q   <= in_ch.button;
			level_q <= in_ch.level_down;
			now_q   <= in_ch.now_ms;
		end
		if (held_for_ld) begin
			held_for_q <= alu_res.res;
		end
		if (fast_ld) begin
			fast_q <= alu_res.ge;
		end
	end

	// ---------------- datapath parts ----------------
	bda_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	bda_btn_regs #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (regs_idx),
		.wr     (regs_wr),
		.rd     (regs_rd)
	);

	bda_out_stage u_ostage (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (os_ctl),
		.sts    (os_sts),
		.out_ch (out_ch)
	);

	// ---------------- checks ----------------
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(bda_pkg::MAX_RESULTS))
		else $error("event budget exceeded");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_BURST))
		else $error("repeat burst exceeded");
	a_edge_held: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bda_pkg::ST_EDGE_EMIT && os_sts.emit_ok) |=> (regs_rd.held == level_q))
		else $error("held flag does not follow accepted edge");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bda_pkg::ST_IDLE) |-> !os_sts.hold_v)
		else $error("staged event left behind at item end");

endmodule
